[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

[rtl/spq_pkg.sv]
// Package for the sorted priority queue: sizes, codes and cell control type.
// No dependencies; imported by the interfaces, the cell and the top level.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int PAY_W    = 16;
  localparam int KEY_W    = 10;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 3;
  localparam int OCC_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_POPPED    = 3'd1,
    ST_POP_EMPTY = 3'd2,
    ST_DROP_FULL = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef struct packed {
    logic ins;       // shift in the new word at the sorted position
    logic pop;       // shift everything one cell toward the head
    logic occupied;  // this cell holds a live entry
  } cell_ctrl_t;

endpackage

[rtl/spq_in_if.sv]
// Input channel: valid/ready handshake carrying one operation word.
// Depends on spq_pkg for field widths.
interface spq_in_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, opcode, key, payload, input ready);
  modport sink   (input valid, opcode, key, payload, output ready);
endinterface

[rtl/spq_out_if.sv]
// Result channel: valid/ready handshake carrying one result word.
// Depends on spq_pkg for field widths.
interface spq_out_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [KEY_W-1:0]  out_key;
  logic [PAY_W-1:0]  out_payload;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, status, out_key, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_key, out_payload, occupancy, output ready);
endinterface

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds a key and payload, trades with neighbors.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] new_key,
  input  logic [PAY_W-1:0] new_payload,
  input  logic             left_ge,
  input  logic [KEY_W-1:0] left_key,
  input  logic [PAY_W-1:0] left_payload,
  input  logic [KEY_W-1:0] right_key,
  input  logic [PAY_W-1:0] right_payload,
  output logic             ge,
  output logic [KEY_W-1:0] key,
  output logic [PAY_W-1:0] payload
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;

  // Entry stays ahead of the new word when its key is greater or equal.
  assign ge = ctrl.occupied && (key_r >= new_key);

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctrl.ins && !ge) begin
      if (left_ge) begin
        key_nxt = new_key;
        pay_nxt = new_payload;
      end else begin
        key_nxt = left_key;
        pay_nxt = left_payload;
      end
    end else if (ctrl.pop) begin
      key_nxt = right_key;
      pay_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key     = key_r;
  assign payload = pay_r;

endmodule

[rtl/sorted_priority_queue.sv]
// Sorted priority queue top level: chain of slot cells, fill count, result register.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_cell and assert_macros.svh.
//
// Holds up to CAPACITY (key, payload) entries in descending key order, head in
// cell 0. Each input word is an insert, a pop (opcode 3 acts as a pop) or a
// clear, and yields exactly one result word in the cycle after acceptance. An
// insert lands behind every entry with a greater or equal key, so equal keys
// leave first-in first-out; an insert into a full queue is dropped and flagged,
// and a pop of an empty queue is flagged with zero key and payload. Rate: one
// word per cycle while out_s.ready holds. Every cell compares its key against
// the new key in the same cycle and the whole row shifts at once, so the only
// sequential element on the word path is the single result register; the input
// stays ready while that register is empty or being drained. Slot contents are
// not cleared after reset or by a clear: the fill count alone marks live cells,
// so there is no clearing pass and the block is ready right out of reset.
`include "assert_macros.svh"

module sorted_priority_queue import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_s,
  spq_out_if.source out_s
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;
  logic [PAY_W-1:0] opay_r, opay_nxt;
  logic [CNT_W-1:0] occ_r;

  logic in_acc, is_ins, is_clr, is_pop, full, empty;
  logic do_ins, do_pop;

  logic             cell_ge  [CAPACITY];
  logic [KEY_W-1:0] cell_key [CAPACITY];
  logic [PAY_W-1:0] cell_pay [CAPACITY];

  // Accept while the result register is empty or draining this cycle; hold
  // ready low during reset so no word is taken and lost.
  assign in_s.ready = rst_n && (!out_valid_r || out_s.ready);
  assign in_acc     = in_s.valid && in_s.ready;

  assign is_ins = (in_s.opcode == OP_INSERT);
  assign is_clr = (in_s.opcode == OP_CLEAR);
  assign is_pop = !is_ins && !is_clr;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign do_ins = in_acc && is_ins && !full;
  assign do_pop = in_acc && is_pop && !empty;

  // Row of cells; the head sees a "greater or equal" neighbor so that it
  // takes the new word whenever its own entry yields.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t       ctrl;
    logic             l_ge;
    logic [KEY_W-1:0] l_key, r_key;
    logic [PAY_W-1:0] l_pay, r_pay;

    assign ctrl.ins      = do_ins;
    assign ctrl.pop      = do_pop;
    assign ctrl.occupied = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign l_ge  = 1'b1;
      assign l_key = in_s.key;
      assign l_pay = in_s.payload;
    end else begin : g_mid
      assign l_ge  = cell_ge[i-1];
      assign l_key = cell_key[i-1];
      assign l_pay = cell_pay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key = cell_key[i];
      assign r_pay = cell_pay[i];
    end else begin : g_body
      assign r_key = cell_key[i+1];
      assign r_pay = cell_pay[i+1];
    end

    spq_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .new_key       (in_s.key),
      .new_payload   (in_s.payload),
      .left_ge       (l_ge),
      .left_key      (l_key),
      .left_payload  (l_pay),
      .right_key     (r_key),
      .right_payload (r_pay),
      .ge            (cell_ge[i]),
      .key           (cell_key[i]),
      .payload       (cell_pay[i])
    );
  end

  // Fill count and the result word for the accepted operation.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    okey_nxt   = '0;
    opay_nxt   = '0;
    priority if (is_ins) begin
      if (full) begin
        status_nxt = ST_DROP_FULL;
      end else begin
        status_nxt = ST_INSERTED;
        count_nxt  = count_r + CNT_W'(1);
      end
    end else if (is_clr) begin
      status_nxt = ST_CLEARED;
      count_nxt  = '0;
    end else begin
      if (empty) begin
        status_nxt = ST_POP_EMPTY;
      end else begin
        status_nxt = ST_POPPED;
        okey_nxt   = cell_key[0];
        opay_nxt   = cell_pay[0];
        count_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      okey_r   <= okey_nxt;
      opay_r   <= opay_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_s.valid       = out_valid_r;
  assign out_s.status      = status_r;
  assign out_s.out_key     = okey_r;
  assign out_s.out_payload = opay_r;
  assign out_s.occupancy   = OCC_W'(occ_r);

  // Fill count never passes capacity.
  `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  // A pop on a non-empty queue removes exactly one entry and reports it.
  `SPQ_ASSERT_NEXT(a_pop_count, clk, rst_n, do_pop, out_valid_r && status_r == ST_POPPED && count_r == $past(count_r) - CNT_W'(1))
  // A dropped insert leaves the fill count alone.
  `SPQ_ASSERT_NEXT(a_full_hold, clk, rst_n, in_acc && is_ins && full, count_r == $past(count_r) && status_r == ST_DROP_FULL)
  // Head and second cell stay in descending order while both are live.
  `SPQ_ASSERT_NOW(a_head_order, clk, rst_n, count_r >= CNT_W'(2), cell_key[0] >= cell_key[1])

endmodule
